[rtl/core/fftr_pkg.sv]
// ----------------------------------------------------------------------------
// fftr_pkg
// Shared constants and the divider slot type for the flat-field correction.
// ----------------------------------------------------------------------------
package fftr_pkg;

  // Field widths of the item ports
  localparam int PIX_W      = 16;
  // Significant pixel bits; the upper field bits are dropped
  localparam int PIXEL_BITS = 16;

  // Interpolation weight, Q1.16, one is 2^16
  localparam int FRAC_BITS = 16;
  localparam int WEIGHT_W  = FRAC_BITS + 1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << FRAC_BITS);

  // Interpolated flat scaled by 2^16, and flat minus dark, fit in this width
  localparam int FLAT_W = PIXEL_BITS + FRAC_BITS;

  // Ratio, Q8.16: quotient of (sample - dark) * 2^32 over the scaled flat minus dark
  localparam int RATIO_W   = 24;
  localparam int NUM_SHIFT = 32;
  localparam int REM_SHIFT = NUM_SHIFT - RATIO_W;
  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

  // Quotient bits resolved per divider stage
  localparam int STEP_BITS  = 2;
  localparam int DIV_STAGES = RATIO_W / STEP_BITS;

  // Payload moving down the divider
  typedef struct packed {
    logic               invalid;
    logic               sat;
    logic [FLAT_W-1:0]  rem;
    logic [FLAT_W-1:0]  divisor;
    logic [RATIO_W-1:0] quot;
  } div_slot_t;

endpackage

[rtl/core/fftr_div_stage.sv]
// ----------------------------------------------------------------------------
// fftr_div_stage
// One registered stage of the restoring divider, resolving STEP_BITS bits.
// ----------------------------------------------------------------------------
module fftr_div_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  fftr_pkg::div_slot_t in_slot,
  output logic              out_valid,
  output fftr_pkg::div_slot_t out_slot
);
  import fftr_pkg::*;

  div_slot_t slot_next;

  always_comb begin
    logic [FLAT_W:0] shifted;
    logic            take;
    slot_next = in_slot;
    for (int i = 0; i < STEP_BITS; i++) begin
      shifted = {slot_next.rem, 1'b0};
      take    = (shifted >= {1'b0, slot_next.divisor});
      if (take) begin
        shifted = shifted - {1'b0, slot_next.divisor};
      end
      slot_next.rem  = shifted[FLAT_W-1:0];
      slot_next.quot = {slot_next.quot[RATIO_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_slot <= slot_next;
    end
  end

endmodule

[rtl/core/flat_field_transmittance.sv]
// ----------------------------------------------------------------------------
// flat_field_transmittance
// Per-pixel dark and flat-field correction giving transmittance in Q8.16.
// ----------------------------------------------------------------------------
// One item (dark, flat before, flat after, sample) enters per clock and one
// result leaves per clock while the consumer does not stall. The accepting
// edge loads the weight products; the item then passes the dark subtraction
// register, the divider seed register, twelve restoring divider stages that
// resolve two quotient bits each, and the output register. The pipeline
// advances as a whole; it holds only while a result sits in the output
// register and the consumer stalls, so in_stall follows that condition.
// The weight register keeps its value saturated at one (2^16) and should be
// written only while no item is in flight. invalid is raised, with ratio 0,
// when flat minus dark or sample minus dark is not positive; an oversized
// quotient saturates ratio at its maximum.
// ----------------------------------------------------------------------------
module flat_field_transmittance (
  input  logic                              clk,
  input  logic                              rst,
  // weight write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fftr_pkg::WEIGHT_W-1:0]     cfg_data,
  // item input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [fftr_pkg::PIX_W-1:0]        dark_pixel,
  input  logic [fftr_pkg::PIX_W-1:0]        flat_before,
  input  logic [fftr_pkg::PIX_W-1:0]        flat_after,
  input  logic [fftr_pkg::PIX_W-1:0]        sample_pixel,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fftr_pkg::RATIO_W-1:0]      ratio,
  output logic                              invalid
);
  import fftr_pkg::*;

  // Pipeline enable: advance unless a result is held at the output
  logic en;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // Weight register, saturated at one on write
  logic [WEIGHT_W-1:0] weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= '0;
    end else if (cfg_valid && cfg_ready) begin
      weight <= (cfg_data > WEIGHT_ONE) ? WEIGHT_ONE : cfg_data;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: weight the two flats
  // --------------------------------------------------------------------------
  logic [WEIGHT_W-1:0] weight_before;
  logic [FLAT_W-1:0]   prod_before_next;
  logic [FLAT_W-1:0]   prod_after_next;

  assign weight_before    = WEIGHT_ONE - weight;
  assign prod_before_next = {{(FLAT_W-WEIGHT_W){1'b0}}, weight_before} *
                            {{(FLAT_W-PIXEL_BITS){1'b0}}, flat_before[PIXEL_BITS-1:0]};
  assign prod_after_next  = {{(FLAT_W-WEIGHT_W){1'b0}}, weight} *
                            {{(FLAT_W-PIXEL_BITS){1'b0}}, flat_after[PIXEL_BITS-1:0]};

  logic                  s1_valid;
  logic [FLAT_W-1:0]     s1_prod_before;
  logic [FLAT_W-1:0]     s1_prod_after;
  logic [PIXEL_BITS-1:0] s1_dark;
  logic [PIXEL_BITS-1:0] s1_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod_before <= prod_before_next;
      s1_prod_after  <= prod_after_next;
      // drop field bits above the pixel width
      s1_dark        <= dark_pixel[PIXEL_BITS-1:0];
      s1_sample      <= sample_pixel[PIXEL_BITS-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: sum the flat and subtract dark from flat and sample
  // --------------------------------------------------------------------------
  logic [FLAT_W:0]     flat_sum;
  logic [FLAT_W+1:0]   flat_diff;
  logic [PIXEL_BITS:0] samp_diff;
  logic                flat_ok;
  logic                samp_ok;

  assign flat_sum  = {1'b0, s1_prod_before} + {1'b0, s1_prod_after};
  assign flat_diff = {1'b0, flat_sum} - {2'b00, s1_dark, {FRAC_BITS{1'b0}}};
  assign samp_diff = {1'b0, s1_sample} - {1'b0, s1_dark};
  assign flat_ok   = !flat_diff[FLAT_W+1] && (flat_diff != '0);
  assign samp_ok   = !samp_diff[PIXEL_BITS] && (samp_diff != '0);

  logic                  s2_valid;
  logic                  s2_invalid;
  logic [FLAT_W-1:0]     s2_divisor;
  logic [PIXEL_BITS-1:0] s2_numer;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_invalid <= !(flat_ok && samp_ok);
      // positive flat difference stays below 2^FLAT_W
      s2_divisor <= flat_diff[FLAT_W-1:0];
      s2_numer   <= samp_diff[PIXEL_BITS-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: seed the divider and detect an oversized quotient
  // --------------------------------------------------------------------------
  logic [FLAT_W-1:0] rem_seed;
  div_slot_t         slot_seed;

  // the quotient overflows RATIO_W bits when numer * 2^REM_SHIFT >= divisor
  assign rem_seed = FLAT_W'({s2_numer, {REM_SHIFT{1'b0}}});

  always_comb begin
    slot_seed.invalid = s2_invalid;
    slot_seed.sat     = (rem_seed >= s2_divisor);
    slot_seed.rem     = rem_seed;
    slot_seed.divisor = s2_divisor;
    slot_seed.quot    = '0;
  end

  logic      vld  [0:DIV_STAGES];
  div_slot_t slot [0:DIV_STAGES];
  logic      seed_valid;
  div_slot_t seed_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_valid <= 1'b0;
    end else if (en) begin
      seed_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seed_slot <= slot_seed;
    end
  end

  assign vld[0]  = seed_valid;
  assign slot[0] = seed_slot;

  // --------------------------------------------------------------------------
  // Divider stages
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    fftr_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (vld[g]),
      .in_slot   (slot[g]),
      .out_valid (vld[g+1]),
      .out_slot  (slot[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // Output register: apply invalid and saturation
  // --------------------------------------------------------------------------
  div_slot_t last;
  assign last = slot[DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      invalid <= last.invalid;
      if (last.invalid) begin
        ratio <= '0;
      end else if (last.sat) begin
        ratio <= RATIO_MAX;
      end else begin
        ratio <= last.quot;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    weight <= WEIGHT_ONE)
    else $error("weight register above one");

  a_seed_below_divisor: assert property (@(posedge clk) disable iff (rst)
    vld[0] && !slot[0].invalid && !slot[0].sat |-> slot[0].rem < slot[0].divisor)
    else $error("divider seed not below divisor");

  a_final_rem: assert property (@(posedge clk) disable iff (rst)
    vld[DIV_STAGES] && !last.invalid && !last.sat |-> last.rem < last.divisor)
    else $error("divider remainder not below divisor");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid |-> ratio == '0)
    else $error("invalid result with nonzero ratio");

endmodule

[bench/transmittance_checker.sv]
// ----------------------------------------------------------------------------
// transmittance_checker
// Watches the weight, item and result channels of the flat-field correction,
// predicts each transmittance and compares it with what the block delivers.
// ----------------------------------------------------------------------------
module transmittance_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [fftr_pkg::WEIGHT_W-1:0] cfg_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [fftr_pkg::PIX_W-1:0]   dark_pixel,
  input  logic [fftr_pkg::PIX_W-1:0]   flat_before,
  input  logic [fftr_pkg::PIX_W-1:0]   flat_after,
  input  logic [fftr_pkg::PIX_W-1:0]   sample_pixel,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [fftr_pkg::RATIO_W-1:0] ratio,
  input  logic                         invalid,
  output int unsigned                  mismatch_count,
  output int unsigned                  pixels_in_flight
);
  import fftr_pkg::*;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic               invalid;
  } transmittance_t;

  localparam longint PIX_MASK = (longint'(1) << PIXEL_BITS) - 1;
  localparam int     Q_SHIFT  = 2 * FRAC_BITS;
  localparam int     REPORT_LIMIT = 10;

  logic [WEIGHT_W-1:0] weight_copy;
  transmittance_t      expected_pixels[$];

  // Interpolate the flat, remove the dark level and divide, all exactly.
  function automatic transmittance_t predict_transmittance(
    input logic [PIX_W-1:0]    dark,
    input logic [PIX_W-1:0]    flat_b,
    input logic [PIX_W-1:0]    flat_a,
    input logic [PIX_W-1:0]    sample,
    input logic [WEIGHT_W-1:0] weight
  );
    longint         w, d, fb, fa, s;
    longint         flat_scaled, flat_diff, sample_diff;
    logic [63:0]    num, den, quotient;
    transmittance_t res;
    // a weight above one counts as one
    w  = (weight > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(weight);
    d  = longint'(dark) & PIX_MASK;
    fb = longint'(flat_b) & PIX_MASK;
    fa = longint'(flat_a) & PIX_MASK;
    s  = longint'(sample) & PIX_MASK;
    flat_scaled = ((longint'(1) << FRAC_BITS) - w) * fb + w * fa;
    flat_diff   = flat_scaled - (d << FRAC_BITS);
    sample_diff = s - d;
    res.ratio   = '0;
    res.invalid = 1'b1;
    if (flat_diff > 0 && sample_diff > 0) begin
      num         = sample_diff;
      num         = num << Q_SHIFT;
      den         = flat_diff;
      quotient    = num / den;
      res.invalid = 1'b0;
      res.ratio   = (quotient > RATIO_MAX) ? RATIO_MAX : quotient[RATIO_W-1:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    transmittance_t want;
    if (rst) begin
      expected_pixels.delete();
      weight_copy    = '0;
      mismatch_count = 0;
    end else begin
      // compare before pushing, so a result never meets its own item
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected result: ratio=%0d invalid=%0b", ratio, invalid);
        end else begin
          want = expected_pixels.pop_front();
          if (ratio !== want.ratio || invalid !== want.invalid) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("result mismatch: ratio exp=%0d got=%0d, invalid exp=%0b got=%0b",
                       want.ratio, ratio, want.invalid, invalid);
          end
        end
      end
      // an item taken on a write edge still sees the old weight
      if (in_valid && !in_stall)
        expected_pixels.push_back(predict_transmittance(dark_pixel, flat_before,
                                                        flat_after, sample_pixel,
                                                        weight_copy));
      if (cfg_valid && cfg_ready)
        weight_copy = cfg_data;
    end
    pixels_in_flight = expected_pixels.size();
  end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives pixel items and weight writes into the flat-field correction and
// reports the verdict of the checker that sits beside it.
// ----------------------------------------------------------------------------
// A short directed set covers empty and full pixels, zero and negative
// differences, the saturation edge and a weight above one. Random phases
// follow, each under its own interpolation weight, written while the block
// is empty. Both channels idle in random bursts; one phase holds the result
// side off for a long stretch so the pipeline fills and stalls its input,
// and the final phase runs without any idling.
// ----------------------------------------------------------------------------
module testbench;
  import fftr_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int LONG_HOLD     = 80;
  localparam int DRAIN_CYCLES  = 40;
  localparam int PHASE_ITEMS   = 150;
  localparam int NUM_PHASES    = 9;
  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  logic                clk;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [WEIGHT_W-1:0] cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic [PIX_W-1:0]    dark_pixel;
  logic [PIX_W-1:0]    flat_before;
  logic [PIX_W-1:0]    flat_after;
  logic [PIX_W-1:0]    sample_pixel;
  logic                out_valid;
  logic                out_stall;
  logic [RATIO_W-1:0]  ratio;
  logic                invalid;

  int unsigned fail_count;
  int unsigned pixels_in_flight;
  int unsigned cycle_count;
  int unsigned tx_run_left;
  bit          tx_quiet;
  bit          rx_quiet;
  bit          hold_phase;

  flat_field_transmittance u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .dark_pixel   (dark_pixel),
    .flat_before  (flat_before),
    .flat_after   (flat_after),
    .sample_pixel (sample_pixel),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ratio        (ratio),
    .invalid      (invalid)
  );

  transmittance_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .dark_pixel       (dark_pixel),
    .flat_before      (flat_before),
    .flat_after       (flat_after),
    .sample_pixel     (sample_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .ratio            (ratio),
    .invalid          (invalid),
    .mismatch_count   (fail_count),
    .pixels_in_flight (pixels_in_flight)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Guard against a hung block: give up well past the slowest legal run.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: random stall bursts between runs of free flow, one long
  // hold-off when asked, and none while quiet.
  initial begin : result_side
    int unsigned stall_left;
    int unsigned run_left;
    bit          hold_done;
    out_stall  = 1'b0;
    stall_left = 0;
    run_left   = 0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_phase && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (rx_quiet) begin
        out_stall <= 1'b0;
      end else if (run_left != 0) begin
        out_stall <= 1'b0;
        run_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(0, 11);
        run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(0, 20);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one item and hold it until the block takes it. An optional idle
  // gap goes in front, unless the sender is quiet.
  task automatic send_pixel(input logic [PIX_W-1:0] d, input logic [PIX_W-1:0] fb,
                            input logic [PIX_W-1:0] fa, input logic [PIX_W-1:0] s);
    int unsigned gap;
    gap = 0;
    if (!tx_quiet) begin
      if (tx_run_left != 0) begin
        tx_run_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        gap         = $urandom_range(1, 12);
        tx_run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(0, 20);
      end
    end
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    dark_pixel   <= d;
    flat_before  <= fb;
    flat_after   <= fa;
    sample_pixel <= s;
    // outputs read here still hold their pre-edge values
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pixels_in_flight != 0) @(negedge clk);
  endtask

  // Write the interpolation weight; only called with the pipeline empty.
  task automatic write_weight(input logic [WEIGHT_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Corner pixels: all-zero and all-full, unity ratio, the saturation edge
  // either side, zero and negative differences, the smallest ratio, and
  // flats that differ so the weight matters.
  task automatic send_corner_pixels();
    send_pixel(16'd0,     16'd0,     16'd0,     16'd0);
    send_pixel(PIX_MAX,   PIX_MAX,   PIX_MAX,   PIX_MAX);
    send_pixel(16'd0,     PIX_MAX,   PIX_MAX,   PIX_MAX);
    send_pixel(16'd0,     16'd1,     16'd1,     PIX_MAX);
    send_pixel(16'd0,     16'd256,   16'd256,   PIX_MAX);
    send_pixel(16'd0,     16'd255,   16'd255,   PIX_MAX);
    send_pixel(16'd100,   16'd100,   16'd100,   16'd200);
    send_pixel(16'd100,   16'd200,   16'd200,   16'd100);
    send_pixel(16'd200,   16'd100,   16'd100,   16'd300);
    send_pixel(16'd0,     PIX_MAX,   PIX_MAX,   16'd1);
    send_pixel(16'd1234,  16'd0,     PIX_MAX,   16'd40000);
    send_pixel(16'd1000,  16'd60000, 16'd2000,  16'd30000);
  endtask

  function automatic logic [PIX_W-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return PIX_W'(1);
      2: return PIX_MAX - PIX_W'(1);
      default: return PIX_MAX;
    endcase
  endfunction

  // Mostly well-formed pixels (flat and sample above dark), with a share
  // near saturation, deliberately invalid ones, raw noise and field extremes.
  task automatic make_random_pixel(output logic [PIX_W-1:0] d, output logic [PIX_W-1:0] fb,
                                   output logic [PIX_W-1:0] fa, output logic [PIX_W-1:0] s);
    int unsigned kind;
    int unsigned dk;
    kind = $urandom_range(0, 99);
    dk   = $urandom_range(0, 60000);
    if (kind < 55) begin
      d  = PIX_W'(dk);
      fb = PIX_W'(dk + $urandom_range(1, PIX_MAX - dk));
      fa = PIX_W'(dk + $urandom_range(1, PIX_MAX - dk));
      s  = PIX_W'(dk + $urandom_range(1, PIX_MAX - dk));
    end else if (kind < 70) begin
      d  = PIX_W'(dk);
      fb = PIX_W'(dk + $urandom_range(1, 300));
      fa = PIX_W'(dk + $urandom_range(1, 300));
      s  = PIX_W'(dk + $urandom_range(1, PIX_MAX - dk));
    end else if (kind < 80) begin
      d  = PIX_W'(dk + $urandom_range(0, 100));
      fb = $urandom_range(0, 1) ? d : PIX_W'($urandom_range(0, dk));
      fa = $urandom_range(0, 1) ? d : PIX_W'($urandom_range(0, PIX_MAX));
      s  = $urandom_range(0, 1) ? d : PIX_W'($urandom_range(0, PIX_MAX));
    end else if (kind < 95) begin
      d  = PIX_W'($urandom);
      fb = PIX_W'($urandom);
      fa = PIX_W'($urandom);
      s  = PIX_W'($urandom);
    end else begin
      d  = pick_extreme();
      fb = pick_extreme();
      fa = pick_extreme();
      s  = pick_extreme();
    end
  endtask

  initial begin : stimulus
    logic [WEIGHT_W-1:0] phase_weight[NUM_PHASES];
    logic [PIX_W-1:0]    d, fb, fa, s;
    // hold every input at a known level from the first instant
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    dark_pixel   = '0;
    flat_before  = '0;
    flat_after   = '0;
    sample_pixel = '0;
    tx_quiet     = 1'b0;
    rx_quiet     = 1'b0;
    hold_phase   = 1'b0;
    tx_run_left  = 0;

    // half, one, the smallest step, just below one, all ones (above one),
    // just above one, random anywhere, back to zero, random up to one
    phase_weight[0] = WEIGHT_ONE >> 1;
    phase_weight[1] = WEIGHT_ONE;
    phase_weight[2] = WEIGHT_W'(1);
    phase_weight[3] = WEIGHT_ONE - WEIGHT_W'(1);
    phase_weight[4] = '1;
    phase_weight[5] = WEIGHT_ONE + WEIGHT_W'(1);
    phase_weight[6] = WEIGHT_W'($urandom_range(0, (1 << WEIGHT_W) - 1));
    phase_weight[7] = '0;
    phase_weight[8] = WEIGHT_W'($urandom_range(0, WEIGHT_ONE));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // corner set under the reset weight, then again with a weight above one
    send_corner_pixels();
    wait_drained();
    write_weight('1);
    send_corner_pixels();

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_weight(phase_weight[p]);
      // phase one: sender flat out while the result side holds off
      tx_quiet   = (p == 1) || (p == NUM_PHASES - 1);
      rx_quiet   = (p == NUM_PHASES - 1);
      hold_phase = (p >= 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        make_random_pixel(d, fb, fa, s);
        send_pixel(d, fb, fa, s);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pixels_in_flight == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
